// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules of the page index block; rpi_walk uses them.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// A condition that, whenever it holds, must be met by a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rpi_pkg.sv =====
// Shared types, field widths and codes for the radix page index block.
// No dependencies; used by rpi_walk and radix_page_index.
`default_nettype none

package rpi_pkg;

  // Default tree geometry.
  localparam int LEVELS_DEF     = 3;
  localparam int SLOT_BITS_DEF  = 6;
  localparam int NODE_POOL_DEF  = 256;
  localparam int FRAME_BITS_DEF = 40;

  // Fixed field widths of the stream beats and the configuration register.
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 18;
  localparam int IN_FRAME_W  = 40;
  localparam int OUT_FRAME_W = 40;
  localparam int STATUS_W    = 3;
  localparam int LIMIT_W     = 19;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [INDEX_W-1:0]    page_index;
    logic [IN_FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [OUT_FRAME_W-1:0] found_frame;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpi_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module rpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic                     re,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic       [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rpi_walk.sv =====
// Tree walk sequencer: clearing pass, node allocation and read-modify-write of the node store.
// Depends on rpi_pkg, rpi_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rpi_walk #(
  parameter int LEVELS     = rpi_pkg::LEVELS_DEF,
  parameter int SLOT_BITS  = rpi_pkg::SLOT_BITS_DEF,
  parameter int NODE_POOL  = rpi_pkg::NODE_POOL_DEF,
  parameter int FRAME_BITS = rpi_pkg::FRAME_BITS_DEF
) (
  input  wire  logic                         clk,
  input  wire  logic                         rst_n,
  input  wire  logic [rpi_pkg::LIMIT_W-1:0]  page_limit,
  input  wire  logic                         req_valid,
  output logic                               req_ready,
  input  wire  rpi_pkg::req_t                req,
  output logic                               rsp_valid,
  input  wire  logic                         rsp_ready,
  output rpi_pkg::rsp_t                      rsp
);

  localparam int NODE_W = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int CNT_W  = $clog2(NODE_POOL + 1);
  localparam int DEPTH  = NODE_POOL * (2 ** SLOT_BITS);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DATA_W = (FRAME_BITS > NODE_W) ? FRAME_BITS : NODE_W;
  localparam int WALK_W = LEVELS * SLOT_BITS;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [rpi_pkg::IN_FRAME_W-1:0] FRAME_MASK =
    (FRAME_BITS >= rpi_pkg::IN_FRAME_W) ? '1 :
    ((rpi_pkg::IN_FRAME_W'(1) << FRAME_BITS) - rpi_pkg::IN_FRAME_W'(1));

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_BUILD, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0]    next_free_r, next_free_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [WALK_W-1:0]   walk_r, walk_nxt;
  logic [rpi_pkg::OP_W-1:0] op_r, op_nxt;
  logic [DATA_W-1:0]   frame_r, frame_nxt;
  rpi_pkg::rsp_t       rsp_r, rsp_nxt;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  logic [SLOT_BITS-1:0]        slot;
  logic [NODE_W+SLOT_BITS-1:0] addr_full;
  logic [ADDR_W-1:0]           cur_addr;
  logic [NODE_W-1:0]           child_lo;
  logic                        child_ok;
  logic                        pool_left;
  logic                        root_present;
  logic                        out_of_range;
  logic [rpi_pkg::IN_FRAME_W-1:0] req_frame_m;
  logic [NODE_W-1:0]           new_node;

  rpi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The slot for the current level sits in the top bits of the walk register.
  assign slot      = walk_r[WALK_W-1 -: SLOT_BITS];
  assign addr_full = {node_r, slot};
  assign cur_addr  = addr_full[ADDR_W-1:0];

  // A child link counts only if it names a real pool node other than the root.
  assign child_lo  = ram_rdata[NODE_W-1:0];
  assign child_ok  = (ram_rdata != '0) && ((ram_rdata >> NODE_W) == '0) &&
                     ({1'b0, child_lo} < (NODE_W + 1)'(NODE_POOL));
  assign pool_left = next_free_r < CNT_W'(NODE_POOL);
  assign new_node  = next_free_r[NODE_W-1:0];
  // The root is always the first node handed out.
  assign root_present = next_free_r != '0;

  assign req_frame_m  = req.frame & FRAME_MASK;
  assign out_of_range = rpi_pkg::LIMIT_W'(req.page_index) >= page_limit;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    next_free_nxt = next_free_r;
    node_nxt      = node_r;
    lvl_nxt       = lvl_r;
    walk_nxt      = walk_r;
    op_nxt        = op_r;
    frame_nxt     = frame_r;
    rsp_nxt       = rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_addr;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = cur_addr;
    req_ready     = 1'b0;
    rsp_valid     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_nxt              = req.op;
          frame_nxt           = DATA_W'(req_frame_m);
          walk_nxt            = WALK_W'(req.page_index);
          node_nxt            = '0;
          lvl_nxt             = LVL_W'(LEVELS - 1);
          rsp_nxt.found_frame = '0;
          unique case (req.op)
            rpi_pkg::OP_LOOKUP: begin
              if (out_of_range) begin
                rsp_nxt.status = rpi_pkg::ST_RANGE;
                state_nxt      = S_DONE;
              end else if (!root_present) begin
                rsp_nxt.status = rpi_pkg::ST_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            rpi_pkg::OP_INSERT: begin
              if (out_of_range) begin
                rsp_nxt.status = rpi_pkg::ST_RANGE;
                state_nxt      = S_DONE;
              end else if (req_frame_m == '0) begin
                rsp_nxt.status = rpi_pkg::ST_NO_SPACE;
                state_nxt      = S_DONE;
              end else if (!root_present) begin
                // Hand out the root and build the whole path below it.
                next_free_nxt = next_free_r + 1'b1;
                state_nxt     = S_BUILD;
              end else begin
                state_nxt = S_READ;
              end
            end
            rpi_pkg::OP_REMOVE: begin
              if (!root_present) begin
                rsp_nxt.status = rpi_pkg::ST_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              // The spare op code is dropped without a result.
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (lvl_r != '0) begin
          if (child_ok) begin
            node_nxt  = child_lo;
            lvl_nxt   = lvl_r - 1'b1;
            walk_nxt  = walk_r << SLOT_BITS;
            state_nxt = S_READ;
          end else if (op_r == rpi_pkg::OP_INSERT) begin
            state_nxt = S_BUILD;
          end else begin
            rsp_nxt.status = rpi_pkg::ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
          unique case (op_r)
            rpi_pkg::OP_LOOKUP: begin
              if (ram_rdata != '0) begin
                rsp_nxt.status      = rpi_pkg::ST_OK;
                rsp_nxt.found_frame = rpi_pkg::OUT_FRAME_W'(ram_rdata);
              end else begin
                rsp_nxt.status = rpi_pkg::ST_NOT_FOUND;
              end
            end
            rpi_pkg::OP_INSERT: begin
              if (ram_rdata != '0) begin
                rsp_nxt.status = (ram_rdata == frame_r) ? rpi_pkg::ST_OK
                                                         : rpi_pkg::ST_CONFLICT;
              end else begin
                ram_we         = 1'b1;
                ram_wdata      = frame_r;
                rsp_nxt.status = rpi_pkg::ST_OK;
              end
            end
            default: begin
              // Remove: hand back the old frame and empty the slot.
              if (ram_rdata != '0) begin
                ram_we              = 1'b1;
                rsp_nxt.status      = rpi_pkg::ST_OK;
                rsp_nxt.found_frame = rpi_pkg::OUT_FRAME_W'(ram_rdata);
              end else begin
                rsp_nxt.status = rpi_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end
      end

      S_BUILD: begin
        // Fresh nodes are known to be empty, so the path is written without reads.
        if (lvl_r == '0) begin
          ram_we         = 1'b1;
          ram_wdata      = frame_r;
          rsp_nxt.status = rpi_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else if (pool_left) begin
          ram_we        = 1'b1;
          ram_wdata     = DATA_W'(new_node);
          node_nxt      = new_node;
          next_free_nxt = next_free_r + 1'b1;
          lvl_nxt       = lvl_r - 1'b1;
          walk_nxt      = walk_r << SLOT_BITS;
        end else begin
          rsp_nxt.status = rpi_pkg::ST_NO_SPACE;
          state_nxt      = S_DONE;
        end
      end

      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      next_free_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      next_free_r <= next_free_nxt;
    end
    node_r  <= node_nxt;
    lvl_r   <= lvl_nxt;
    walk_r  <= walk_nxt;
    op_r    <= op_nxt;
    frame_r <= frame_nxt;
    rsp_r   <= rsp_nxt;
  end

  assign rsp = rsp_r;

  // Reads and writes are sequenced so that the store never sees both in one cycle.
  `ASSERT_ALWAYS(a_single_access, !(ram_we && ram_re), "store read and written in one cycle")
  // A write after a check goes back to the entry that was just read.
  `ASSERT_IMPLIES(a_rmw_addr, (state_r == S_CHECK) && ram_we, ram_waddr == $past(ram_raddr), "write-back address differs from read")
  // Building only ever stores child links or valid frames.
  `ASSERT_IMPLIES(a_build_nonzero, (state_r == S_BUILD) && ram_we, ram_wdata != '0, "build wrote an empty entry")

endmodule

`default_nettype wire

// ===== hw/rtl/radix_page_index.sv =====
// Radix tree page index: maps page indexes to frame numbers held in an on-chip node store.
// Top level; depends on rpi_pkg, rpi_walk and rpi_ram.
//
// Usage
//   Requests arrive as beats on the in_ stream: in_tuser carries the operation (lookup,
//   insert or remove) and in_tdata the page index and the frame. Every lookup, insert and
//   remove returns exactly one beat on the out_ stream with a status in out_tuser and the
//   found or removed frame in out_tdata. The spare operation code is taken and dropped.
//   The user writes the page limit via cfg_we/cfg_wdata only while idle; not enforced.
//
//   One request is worked on at a time. Each tree level is a registered read of the node
//   store, then a check and possible write-back, set by the one port pair of the store.
//   A lookup or insert out of range and a lookup or remove on an empty tree skip the walk.
//   An insert that builds the path writes one new node per cycle instead of reading.
//
//   After reset the block clears all NODE_POOL times 2^SLOT_BITS entries of the node store
//   (16384 by default) one entry per cycle, with in_tready held low; config writes are
//   still taken. A result waits in the output register while the receiver stalls, and
//   the next request may be accepted and worked on meanwhile; the sequencer then holds
//   its finished result until the output register is free.
`default_nettype none

module radix_page_index #(
  parameter int LEVELS     = rpi_pkg::LEVELS_DEF,
  parameter int SLOT_BITS  = rpi_pkg::SLOT_BITS_DEF,
  parameter int NODE_POOL  = rpi_pkg::NODE_POOL_DEF,
  parameter int FRAME_BITS = rpi_pkg::FRAME_BITS_DEF
) (
  input  wire  logic                            clk,
  input  wire  logic                            rst_n,
  // Configuration: page_limit.
  input  wire  logic                            cfg_we,
  input  wire  logic [rpi_pkg::LIMIT_W-1:0]     cfg_wdata,
  // Request stream.
  input  wire  logic                            in_tvalid,
  output logic                                  in_tready,
  // in_tdata fields from bit 0: page_index[17:0], frame[57:18], zero pad[63:58].
  input  wire  logic [rpi_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser fields from bit 0: op[1:0].
  input  wire  logic [rpi_pkg::OP_W-1:0]        in_tuser,
  // Result stream.
  output logic                                  out_tvalid,
  input  wire  logic                            out_tready,
  // out_tdata fields from bit 0: found_frame[39:0].
  output logic [rpi_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // out_tuser fields from bit 0: status[2:0].
  output logic [rpi_pkg::STATUS_W-1:0]          out_tuser
);

  logic [rpi_pkg::LIMIT_W-1:0] page_limit_r;

  rpi_pkg::req_t req;
  rpi_pkg::rsp_t rsp;
  logic          rsp_valid, rsp_ready;

  logic          out_valid_r;
  rpi_pkg::rsp_t out_rsp_r;

  // The page limit is a plain register; its reset value covers every index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r <= rpi_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      page_limit_r <= cfg_wdata;
    end
  end

  // Unpack the request beat; the pad bits above the frame are not looked at.
  assign req.op         = in_tuser;
  assign req.page_index = in_tdata[rpi_pkg::INDEX_W-1:0];
  assign req.frame      = in_tdata[rpi_pkg::INDEX_W +: rpi_pkg::IN_FRAME_W];

  rpi_walk #(
    .LEVELS     (LEVELS),
    .SLOT_BITS  (SLOT_BITS),
    .NODE_POOL  (NODE_POOL),
    .FRAME_BITS (FRAME_BITS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .page_limit (page_limit_r),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

  // Output register: it is loaded whenever it is empty or its beat leaves in this cycle,
  // so a stalled receiver only holds back the sequencer once a second result is done.
  assign rsp_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_r <= rsp_valid;
    end
    if (rsp_valid && rsp_ready) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rsp_r.found_frame;
  assign out_tuser  = out_rsp_r.status;

endmodule

`default_nettype wire

// ===== tb/radix_page_index_tb.sv =====
// Self-checking testbench for radix_page_index: request/result streams plus page_limit writes.
// Depends on rpi_pkg and the radix_page_index RTL; predicts every result with its own tree copy.
`timescale 1ns / 100ps

module radix_page_index_tb;
  import rpi_pkg::*;

  // Tree geometry of the instance under test (the block's defaults).
  localparam int LEVELS       = LEVELS_DEF;
  localparam int SLOT_BITS    = SLOT_BITS_DEF;
  localparam int NODE_POOL    = NODE_POOL_DEF;
  localparam int SLOTS        = 1 << SLOT_BITS;
  localparam int STORE_DEPTH  = NODE_POOL << SLOT_BITS;
  // The spare operation code is taken by the block and dropped without a result.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
  localparam logic [IN_FRAME_W-1:0] FRAME_MAX = '1;
  // The quiet tail covers a full walk; a margin on top covers a dropped spare-code beat.
  localparam int QUIET_CYCLES = 2 * LEVELS + 2 + 8;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radix_page_index dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // ---------------------------------------------------------------------------------------
  // Predictor state: our own copy of the node store, the allocator and the page limit.
  // Upper-level slots hold child node numbers, leaf slots hold frames; zero means empty.
  // ---------------------------------------------------------------------------------------
  logic [IN_FRAME_W-1:0] tree_mem [STORE_DEPTH];
  bit                    root_made;
  int unsigned           root_id;
  int unsigned           nodes_used;
  logic [LIMIT_W-1:0]    limit_model;

  req_t requests_todo [$];   // beats still to be offered by the driver
  rsp_t outcomes_due  [$];   // results the block still owes, oldest first

  int unsigned ops_taken [4];
  int unsigned st_seen [8];
  int unsigned results_checked;
  int unsigned fault_count;

  function automatic int unsigned slot_at(input logic [INDEX_W-1:0] idx, input int lvl);
    return (idx >> (lvl * SLOT_BITS)) & (SLOTS - 1);
  endfunction

  // Walks the tree without building anything; gives the leaf slot address when the path exists.
  function automatic bit leaf_addr(input logic [INDEX_W-1:0] idx, output int unsigned leaf);
    int unsigned node;
    logic [IN_FRAME_W-1:0] child;
    leaf = 0;
    if (!root_made) return 1'b0;
    node = root_id;
    for (int lvl = LEVELS - 1; lvl > 0; lvl--) begin
      child = tree_mem[(node << SLOT_BITS) | slot_at(idx, lvl)];
      if (child == 0 || child >= NODE_POOL) return 1'b0;
      node = 32'(child);
    end
    leaf = (node << SLOT_BITS) | slot_at(idx, 0);
    return 1'b1;
  endfunction

  // Builds the missing part of the path and stores the frame. Nodes linked in before the pool
  // runs dry are left in place, as the block does.
  function automatic logic [STATUS_W-1:0] build_path(input logic [INDEX_W-1:0] idx,
                                                     input logic [IN_FRAME_W-1:0] frame);
    int unsigned node;
    int unsigned addr;
    int unsigned child;
    if (!root_made) begin
      if (nodes_used >= NODE_POOL) return ST_NO_SPACE;
      root_id = nodes_used;
      nodes_used++;
      root_made = 1'b1;
    end
    node = root_id;
    for (int lvl = LEVELS - 1; lvl > 0; lvl--) begin
      addr = (node << SLOT_BITS) | slot_at(idx, lvl);
      if (tree_mem[addr] == 0 || tree_mem[addr] >= NODE_POOL) begin
        if (nodes_used >= NODE_POOL) return ST_NO_SPACE;
        child = nodes_used;
        nodes_used++;
        tree_mem[addr] = IN_FRAME_W'(child);
      end else begin
        child = 32'(tree_mem[addr]);
      end
      node = child;
    end
    tree_mem[(node << SLOT_BITS) | slot_at(idx, 0)] = frame;
    return ST_OK;
  endfunction

  // Applies one lookup, insert or remove to the predictor and returns the result it owes.
  function automatic rsp_t page_op_outcome(input logic [OP_W-1:0] op,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic [IN_FRAME_W-1:0] frame);
    rsp_t r;
    int unsigned leaf;
    bit hit;
    r.status = ST_OK;
    r.found_frame = '0;
    hit = leaf_addr(idx, leaf) && (tree_mem[leaf] != 0);
    case (op)
      OP_LOOKUP: begin
        if ({1'b0, idx} >= limit_model) r.status = ST_RANGE;
        else if (hit) r.found_frame = tree_mem[leaf];
        else r.status = ST_NOT_FOUND;
      end
      OP_INSERT: begin
        // Range is checked before the zero frame, then an occupied slot before building.
        if ({1'b0, idx} >= limit_model) r.status = ST_RANGE;
        else if (frame == 0) r.status = ST_NO_SPACE;
        else if (hit) r.status = (tree_mem[leaf] == frame) ? ST_OK : ST_CONFLICT;
        else r.status = build_path(idx, frame);
      end
      default: begin
        // Remove ignores the page limit.
        if (hit) begin
          r.found_frame = tree_mem[leaf];
          tree_mem[leaf] = '0;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: offers queued requests in bursts of random length separated by random gaps.
  // The prediction is made at the edge where the beat is taken.
  // ---------------------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    req_t head;
    logic offer;
    logic [IN_TDATA_W-1:0] beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        ops_taken[in_tuser]++;
        if (in_tuser != OP_SPARE)
          outcomes_due.push_back(page_op_outcome(in_tuser, in_tdata[INDEX_W-1:0],
                                                 in_tdata[INDEX_W +: IN_FRAME_W]));
      end
      // A new beat may only be set up once the current one has been taken.
      if (!in_tvalid || in_tready) begin
        offer = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (requests_todo.size() != 0) begin
          head = requests_todo.pop_front();
          beat = '0;
          beat[INDEX_W-1:0] = head.page_index;
          beat[INDEX_W +: IN_FRAME_W] = head.frame;
          in_tdata <= beat;
          in_tuser <= head.op;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            // About a third of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_tvalid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: stalls in runs of changing character. Twice in the run it holds off for a long
  // stretch so that the result register and the sequencer fill and in_tready drops.
  // ---------------------------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned holds_done;
  int unsigned stall_run;
  int unsigned stall_mode;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      holds_done = 0;
      stall_run = 0;
      stall_mode = 0;
    end else begin
      if (hold_left == 0 && holds_done < 2 &&
          results_checked >= ((holds_done == 0) ? 60 : 300)) begin
        hold_left = 300;
        holds_done++;
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_run = $urandom_range(10, 60);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 1);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: every result beat is matched against the oldest outstanding prediction.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (outcomes_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: result beat with nothing outstanding: status %0d frame %h",
                   $time, out_tuser, out_tdata);
      end else begin
        want = outcomes_due.pop_front();
        st_seen[want.status]++;
        if (out_tuser !== want.status || out_tdata !== want.found_frame) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("%0t: result %0d mismatch: status %0d frame %h, %s %0d frame %h",
                     $time, results_checked, out_tuser, out_tdata, "expected status",
                     want.status, want.found_frame);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  logic [INDEX_W-1:0]    hot_idx [12];
  logic [IN_FRAME_W-1:0] hot_frame [3];

  function automatic logic [IN_FRAME_W-1:0] any_frame();
    return {8'($urandom_range(0, 255)), 32'($urandom)};
  endfunction

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [IN_FRAME_W-1:0] frame);
    req_t r;
    r.op = op;
    r.page_index = idx;
    r.frame = frame;
    requests_todo.push_back(r);
  endtask

  // Mostly traffic on a small set of hot indexes and frames, so that hits, same-frame inserts,
  // conflicts and removes of live entries are common; the rest is spread over the whole index.
  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    logic [OP_W-1:0] op;
    logic [INDEX_W-1:0] idx;
    logic [IN_FRAME_W-1:0] frame;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_LOOKUP;
      else if (pick < 70) op = OP_INSERT;
      else if (pick < 92) op = OP_REMOVE;
      else op = OP_SPARE;
      idx = ($urandom_range(0, 99) < 80) ? hot_idx[$urandom_range(0, 11)] : INDEX_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) frame = hot_frame[$urandom_range(0, 2)];
      else if (pick < 90) frame = any_frame();
      else frame = '0;
      queue_req(op, idx, frame);
    end
  endtask

  // Returns once every queued beat is taken and every result is in, plus a short tail.
  task automatic wait_quiet();
    while (requests_todo.size() != 0 || in_tvalid || outcomes_due.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_model = value;
  endtask

  // Runs the pool down to exactly one free node with inserts that each need new nodes, then
  // drives the pool-exhaustion cases: a half-built path, an insert with no room left, and an
  // insert into a leaf node that already exists.
  task automatic queue_pool_fill();
    bit top_there [SLOTS];
    bit pair_there [SLOTS * SLOTS];
    int unsigned room;
    int unsigned need;
    int unsigned mid_node;
    int unsigned t;
    int unsigned p;
    logic [INDEX_W-1:0] idx;
    logic [INDEX_W-1:0] last_idx;
    logic [IN_FRAME_W-1:0] frame;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      mid_node = 32'(tree_mem[(root_id << SLOT_BITS) | i]);
      top_there[i] = root_made && mid_node != 0;
      for (int unsigned j = 0; j < SLOTS; j++)
        pair_there[i * SLOTS + j] = top_there[i] &&
                                    tree_mem[(mid_node << SLOT_BITS) | j] != 0;
    end
    room = NODE_POOL - nodes_used;
    last_idx = '0;
    while (room > 1) begin
      idx = INDEX_W'($urandom);
      t = 32'(idx[2 * SLOT_BITS +: SLOT_BITS]);
      p = 32'(idx[SLOT_BITS +: 2 * SLOT_BITS]);
      need = (top_there[t] ? 0 : 1) + (pair_there[p] ? 0 : 1);
      if (need != 0 && need < room) begin
        frame = any_frame();
        if (frame == 0) frame = 1;
        queue_req(OP_INSERT, idx, frame);
        top_there[t] = 1'b1;
        pair_there[p] = 1'b1;
        room -= need;
        last_idx = idx;
      end
    end
    // One node left: a path under a new top slot gets its middle node and then runs dry.
    t = SLOTS;
    for (int unsigned i = 0; i < SLOTS; i++)
      if (!top_there[i] && t == SLOTS) t = i;
    if (t != SLOTS) begin
      idx = INDEX_W'($urandom);
      idx[2 * SLOT_BITS +: SLOT_BITS] = SLOT_BITS'(t);
      queue_req(OP_INSERT, idx, hot_frame[2]);
      idx[0] = ~idx[0];
      queue_req(OP_INSERT, idx, hot_frame[1]);
      queue_req(OP_LOOKUP, idx, '0);
    end
    // Existing leaf nodes still take new frames once the pool is gone.
    last_idx[0] = ~last_idx[0];
    queue_req(OP_INSERT, last_idx, hot_frame[0]);
    queue_req(OP_LOOKUP, last_idx, '0);
    queue_req(OP_INSERT, INDEX_W'($urandom), any_frame());
  endtask

  initial begin
    logic [2:0][SLOT_BITS-1:0] tops;
    logic [1:0][SLOT_BITS-1:0] mids;
    foreach (tree_mem[i]) tree_mem[i] = '0;
    root_made = 1'b0;
    root_id = 0;
    nodes_used = 0;
    limit_model = LIMIT_RESET;

    tops[0] = '0;
    tops[1] = SLOT_BITS'($urandom);
    tops[2] = '1;
    mids[0] = SLOT_BITS'($urandom);
    mids[1] = SLOT_BITS'($urandom);
    hot_idx[0] = '0;
    hot_idx[1] = INDEX_MAX;
    for (int k = 2; k < 12; k++)
      hot_idx[k] = {tops[k % 3], mids[(k / 3) % 2], SLOT_BITS'($urandom)};
    hot_frame[0] = 1;
    hot_frame[1] = FRAME_MAX;
    hot_frame[2] = any_frame() | 1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // The block is still clearing its store here, but it takes register writes.
    set_limit(LIMIT_RESET);

    // Empty tree, zero frame, spare code, same-frame and conflicting inserts, both index
    // extremes, remove of a live entry and of one already gone, and an empty leaf slot.
    queue_req(OP_LOOKUP, '0, '0);
    queue_req(OP_REMOVE, '0, '0);
    queue_req(OP_INSERT, '0, '0);
    queue_req(OP_SPARE, INDEX_MAX, FRAME_MAX);
    queue_req(OP_INSERT, '0, 1);
    queue_req(OP_INSERT, '0, 1);
    queue_req(OP_INSERT, '0, FRAME_MAX);
    queue_req(OP_INSERT, INDEX_MAX, FRAME_MAX);
    queue_req(OP_LOOKUP, INDEX_MAX, '0);
    queue_req(OP_REMOVE, INDEX_MAX, '0);
    queue_req(OP_REMOVE, INDEX_MAX, '0);
    queue_req(OP_LOOKUP, INDEX_W'(1), '0);
    queue_req(OP_INSERT, INDEX_W'(200), hot_frame[2]);
    wait_quiet();

    // Small limit: range faults take precedence over a zero frame, remove ignores the limit.
    set_limit(LIMIT_W'(100));
    queue_req(OP_LOOKUP, INDEX_W'(100), '0);
    queue_req(OP_INSERT, INDEX_W'(100), '0);
    queue_req(OP_REMOVE, INDEX_W'(200), '0);
    queue_req(OP_INSERT, INDEX_W'(99), any_frame() | 1);
    queue_req(OP_LOOKUP, INDEX_W'(99), '0);
    queue_req(OP_INSERT, INDEX_W'(50), '0);
    wait_quiet();

    // Zero limit: every lookup and insert is out of range.
    set_limit('0);
    queue_req(OP_LOOKUP, '0, '0);
    queue_req(OP_INSERT, '0, 1);
    queue_req(OP_REMOVE, '0, '0);
    wait_quiet();

    // Random traffic under three limits.
    set_limit(LIMIT_RESET);
    queue_random(70);
    wait_quiet();
    set_limit(LIMIT_W'($urandom_range(1, 262143)));
    queue_random(70);
    wait_quiet();
    set_limit(LIMIT_W'(1));
    queue_random(70);
    wait_quiet();

    set_limit(LIMIT_RESET);
    queue_pool_fill();
    wait_quiet();

    // With the pool gone, only paths that already exist can take new frames.
    set_limit(LIMIT_W'(262143));
    queue_random(90);
    wait_quiet();

    $display("Covered %0d request beats (%0d lookup, %0d insert, %0d remove, %0d spare code),",
             ops_taken[OP_LOOKUP] + ops_taken[OP_INSERT] + ops_taken[OP_REMOVE] +
             ops_taken[OP_SPARE], ops_taken[OP_LOOKUP], ops_taken[OP_INSERT],
             ops_taken[OP_REMOVE], ops_taken[OP_SPARE]);
    $display("%0d results checked; ok %0d, not found %0d, range %0d, conflict %0d, %s %0d;",
             results_checked, st_seen[ST_OK], st_seen[ST_NOT_FOUND], st_seen[ST_RANGE],
             st_seen[ST_CONFLICT], "no space", st_seen[ST_NO_SPACE]);
    $display("%0d of %0d nodes used.", nodes_used, NODE_POOL);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d faults in total", fault_count);
      $display("FAIL");
    end
    $finish;
  end

  // The slowest correct run, including the clearing pass, ends well before this watchdog fires.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", outcomes_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
